// File: hdl/bud_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bud_pkg
// Shared types and byte codes for the byte-unstuffing deframer.
// ----------------------------------------------------------------------------
package bud_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] ESC_OK_A  = 8'h5D;
  localparam logic [7:0] ESC_OK_B  = 8'h5E;

  // Result kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_DATA  = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // Decoder modes
  localparam logic [1:0] MODE_READING = 2'd0;
  localparam logic [1:0] MODE_ESCAPE  = 2'd1;
  localparam logic [1:0] MODE_DONE    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] frame_length;
    logic       frame_ok;
  } bud_result_t;

endpackage
`default_nettype wire

// File: hdl/bud_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bud_in_reg
// Input register: captures one line byte per beat and holds it until the
// decoder takes it.
// ----------------------------------------------------------------------------
module bud_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_line_byte,
  input  wire logic       take,
  output logic            ready,
  output logic            valid_r,
  output logic [7:0]      byte_r
);

  logic       valid_nxt;
  logic [7:0] byte_nxt;
  logic       load;

  // Free when empty or when the held byte leaves this cycle.
  assign ready = !valid_r || take;
  assign load  = in_valid && ready;

  always_comb begin
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    if (load) begin
      valid_nxt = 1'b1;
      byte_nxt  = in_line_byte;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/bud_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bud_decoder
// Unstuffing state (mode, payload count) and the single-pass decode of one
// byte into one result.
// ----------------------------------------------------------------------------
module bud_decoder #(
  parameter int FRAME_MAX = 256
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire,
  input  wire logic [7:0]      line_byte,
  output bud_pkg::bud_result_t result
);
  import bud_pkg::*;

  localparam int CNT_W = $clog2(FRAME_MAX);
  localparam int LEN_W = (CNT_W > 8) ? CNT_W : 8;

  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [1:0]       mode_eff;
  logic [CNT_W-1:0] cnt_eff;
  logic [CNT_W:0]   cnt_inc;
  logic [LEN_W-1:0] cnt_ext;
  logic [7:0]       len_sat;
  logic [7:0]       value;
  logic             esc_ok;

  always_comb begin
    // A finished frame restarts on the next byte.
    mode_eff = (mode_r == MODE_DONE) ? MODE_READING : mode_r;
    cnt_eff  = (mode_r == MODE_DONE) ? '0 : cnt_r;
    cnt_inc  = {1'b0, cnt_eff} + (CNT_W+1)'(1);
    cnt_ext  = LEN_W'(cnt_eff);
    len_sat  = (cnt_ext > LEN_W'(255)) ? 8'hFF : cnt_ext[7:0];
    esc_ok   = (line_byte == ESC_OK_A) || (line_byte == ESC_OK_B);
    value    = (mode_eff == MODE_ESCAPE) ? (line_byte ^ ESC_XOR) : line_byte;

    result   = '0;
    mode_nxt = MODE_READING;
    cnt_nxt  = cnt_eff;

    if (line_byte == FLAG_BYTE) begin
      result.kind         = KIND_END;
      result.frame_length = len_sat;
      result.frame_ok     = (cnt_eff != '0);
      mode_nxt            = MODE_DONE;
    end else if (line_byte == ESC_BYTE) begin
      result.kind = KIND_NONE;
      mode_nxt    = MODE_ESCAPE;
    end else if ((mode_eff == MODE_ESCAPE) && !esc_ok) begin
      result.kind = KIND_ERROR;
      cnt_nxt     = '0;
    end else if (cnt_inc >= (CNT_W+1)'(FRAME_MAX)) begin
      // Frame overrun: drop the byte and report it.
      result.kind = KIND_ERROR;
      cnt_nxt     = '0;
    end else begin
      result.kind      = KIND_DATA;
      result.data_byte = value;
      cnt_nxt          = cnt_inc[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_READING;
      cnt_r  <= '0;
    end else if (fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/bud_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bud_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bud_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load_valid,
  input  wire bud_pkg::bud_result_t load_res,
  input  wire logic                 out_stall,
  output logic                      ready,
  output logic                      valid_r,
  output bud_pkg::bud_result_t      res_r
);
  import bud_pkg::*;

  logic        valid_nxt;
  bud_result_t res_nxt;
  logic        load;

  assign ready = !valid_r || !out_stall;
  assign load  = load_valid && ready;

  always_comb begin
    valid_nxt = valid_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = load_res;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/byte_unstuffing_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_unstuffing_deframer
// HDLC-style byte unstuffing of a received line stream, one result per byte.
// ----------------------------------------------------------------------------
// Every line byte accepted on the in_ channel yields exactly one result beat
// on the out_ channel, in order. kind tells what the byte did: 0 consumed
// (an escape byte), 1 a decoded payload byte on out_data_byte, 2 a frame end
// (flag 0x7E) with out_frame_length and out_frame_ok, 3 an error (bad escaped
// byte, or a payload reaching FRAME_MAX bytes), which drops the partial
// frame. The block takes one byte per clock when the sink does not stall.
// A byte is held in the input register and then moves into the result
// register, from which its result beat is presented; a stall on the out_
// channel can hold it in either register. The decode itself is a single
// compare/increment step on the mode and payload count between the two
// registers, and that state is updated as each byte moves on, so the input
// register can take a new byte while the last one moves on.
// ----------------------------------------------------------------------------
module byte_unstuffing_deframer #(
  parameter int FRAME_MAX = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Line byte channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_line_byte,
  // Result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_kind,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_frame_length,
  output logic            out_frame_ok
);
  import bud_pkg::*;

  logic        in_ready;
  logic        hold_valid_r;
  logic [7:0]  hold_byte_r;
  logic        res_ready;
  logic        dec_fire;
  bud_result_t dec_res;
  bud_result_t res_r;

  // Advance the held byte into the result register whenever that register
  // is empty or its beat is being taken this cycle.
  assign dec_fire = hold_valid_r && res_ready;
  assign in_stall = !in_ready;

  bud_in_reg u_in_reg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_line_byte (in_line_byte),
    .take         (dec_fire),
    .ready        (in_ready),
    .valid_r      (hold_valid_r),
    .byte_r       (hold_byte_r)
  );

  // Decode state updates only when a byte actually moves on.
  bud_decoder #(
    .FRAME_MAX (FRAME_MAX)
  ) u_decoder (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (dec_fire),
    .line_byte (hold_byte_r),
    .result    (dec_res)
  );

  bud_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (hold_valid_r),
    .load_res   (dec_res),
    .out_stall  (out_stall),
    .ready      (res_ready),
    .valid_r    (out_valid),
    .res_r      (res_r)
  );

  assign out_kind         = res_r.kind;
  assign out_data_byte    = res_r.data_byte;
  assign out_frame_length = res_r.frame_length;
  assign out_frame_ok     = res_r.frame_ok;

endmodule
`default_nettype wire
